// ===== rtl/core/chained_hash_map_defines.svh =====
// ----------------------------------------------------------------------------
// chained_hash_map_defines.svh
// Assertion macros for the chained hash map.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_DEFINES_SVH
`define CHAINED_HASH_MAP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside of reset
`define CHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge
`define CHM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHM_ASSERT(lbl, prop, msg)
`define CHM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/chm_pkg.sv =====
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the chained hash map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package chm_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 9;
  localparam int COUNT_W = 9;

  localparam logic [CFG_W-1:0] DEFAULT_BUCKETS = 9'd241;

  typedef enum logic [1:0] {
    MODE_SET    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_DEL    = 2'd2,
    MODE_DELALL = 2'd3
  } mode_t;

endpackage

// ===== rtl/core/chm_ram.sv =====
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/chained_hash_map.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map
// Separately chained hash map over a node pool with a free list.
// ----------------------------------------------------------------------------
// channel   direction  handshake          words
// command   in         start & !busy      mode, key, value
// result    out        done (one cycle)   hit, value_out, full_res, entry_count
// config    in         cfg_we             cfg_data (bucket_count)
//
// Set/get/delete: 32 cycles of bit-serial key modulo, 2 to fetch the bucket
// head, then 2 per node compared; done follows 34 + 2 * nodes compared cycles
// after accept, plus 1 on a miss or refused insert, plus 2 on an insert or delete.
// Delete all: sweep of max(MAX_BUCKETS, POOL_SIZE) cycles rewriting the bucket
// heads and the free list; the same sweep runs after reset, with busy high.
// busy drops in the done cycle, so the next word can be taken at its end.
// The result word is shown for one cycle by done; it cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chained_hash_map_defines.svh"

module chained_hash_map #(
  parameter int MAX_BUCKETS = 256,
  parameter int POOL_SIZE   = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [chm_pkg::KEY_W-1:0]    key,
  input  logic [chm_pkg::VAL_W-1:0]    value,
  input  logic                         cfg_we,
  input  logic [chm_pkg::CFG_W-1:0]    cfg_data,
  output logic                         done,
  output logic                         hit,
  output logic [chm_pkg::VAL_W-1:0]    value_out,
  output logic                         full_res,
  output logic [chm_pkg::COUNT_W-1:0]  entry_count
);

  localparam int BIW   = $clog2(MAX_BUCKETS);
  localparam int PW    = $clog2(POOL_SIZE);
  localparam int NW    = $clog2(POOL_SIZE + 1);
  localparam int CW    = ($clog2(MAX_BUCKETS + 1) > chm_pkg::CFG_W) ?
                         $clog2(MAX_BUCKETS + 1) : chm_pkg::CFG_W;
  localparam int SWEEP = (MAX_BUCKETS > POOL_SIZE) ? MAX_BUCKETS : POOL_SIZE;
  localparam int SW    = $clog2(SWEEP);
  localparam logic [NW-1:0] NIL = NW'(POOL_SIZE);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_BRD   = 10'b0000001000,
    S_HEAD  = 10'b0000010000,
    S_CHK   = 10'b0000100000,
    S_CMP   = 10'b0001000000,
    S_DEL1  = 10'b0010000000,
    S_DEL2  = 10'b0100000000,
    S_ALLOC = 10'b1000000000
  } state_t;

  state_t                      state;
  logic [chm_pkg::CFG_W-1:0]   bucket_count;
  chm_pkg::mode_t              mode_r;
  logic [chm_pkg::KEY_W-1:0]   key_r;
  logic [chm_pkg::VAL_W-1:0]   value_r;
  logic [4:0]                  bit_cnt;
  logic [CW-1:0]               rem;
  logic [SW-1:0]               clr_idx;
  logic                        clr_pend;
  logic [NW-1:0]               cur;
  logic [NW-1:0]               prev;
  logic [NW-1:0]               head;
  logic [NW-1:0]               nnext;
  logic [chm_pkg::VAL_W-1:0]   vout;
  logic [NW-1:0]               free_head;
  logic [NW-1:0]               entry_total;

  // effective bucket count: 0 acts as 1, clamp at MAX_BUCKETS
  logic [CW-1:0] neff;
  logic [CW:0]   trial;
  logic          cur_nil;
  logic          key_match;

  always_comb begin
    if (bucket_count == '0) begin
      neff = CW'(1);
    end else if (CW'(bucket_count) > CW'(MAX_BUCKETS)) begin
      neff = CW'(MAX_BUCKETS);
    end else begin
      neff = CW'(bucket_count);
    end
  end

  assign trial   = {rem, key_r[bit_cnt]};
  assign cur_nil = (cur == NIL);

  // memories
  logic                      bh_we, nk_we, nv_we, nn_we;
  logic [BIW-1:0]            bh_waddr;
  logic [PW-1:0]             nk_waddr, nv_waddr, nn_waddr, nd_raddr, nn_raddr;
  logic [NW-1:0]             bh_wdata, nn_wdata, bh_rdata, nn_rdata;
  logic [chm_pkg::VAL_W-1:0] nv_wdata, nv_rdata;
  logic [chm_pkg::KEY_W-1:0] nk_rdata;

  assign key_match = (nk_rdata == key_r);
  assign nd_raddr  = cur[PW-1:0];
  assign nn_raddr  = cur_nil ? free_head[PW-1:0] : cur[PW-1:0];

  always_comb begin
    bh_we    = 1'b0;
    bh_waddr = rem[BIW-1:0];
    bh_wdata = nnext;
    nk_we    = 1'b0;
    nk_waddr = free_head[PW-1:0];
    nv_we    = 1'b0;
    nv_waddr = cur[PW-1:0];
    nv_wdata = value_r;
    nn_we    = 1'b0;
    nn_waddr = cur[PW-1:0];
    nn_wdata = free_head;
    case (state)
      S_CLEAR: begin
        bh_we    = (32'(clr_idx) < MAX_BUCKETS);
        bh_waddr = BIW'(clr_idx);
        bh_wdata = NIL;
        nn_we    = (32'(clr_idx) < POOL_SIZE);
        nn_waddr = PW'(clr_idx);
        nn_wdata = NW'(32'(clr_idx) + 1);
      end
      S_CMP: begin
        nv_we = key_match && (mode_r == chm_pkg::MODE_SET);
      end
      S_DEL1: begin
        if (prev != NIL) begin
          nn_we    = 1'b1;
          nn_waddr = prev[PW-1:0];
          nn_wdata = nnext;
        end else begin
          bh_we = 1'b1;
        end
      end
      S_DEL2: begin
        nn_we = 1'b1;
      end
      S_ALLOC: begin
        nk_we    = 1'b1;
        nv_we    = 1'b1;
        nv_waddr = free_head[PW-1:0];
        nn_we    = 1'b1;
        nn_waddr = free_head[PW-1:0];
        nn_wdata = head;
        bh_we    = 1'b1;
        bh_wdata = free_head;
      end
      default: begin
      end
    endcase
  end

  chm_ram #(.WIDTH(NW), .DEPTH(MAX_BUCKETS)) u_bucket_head (
    .clk(clk), .we(bh_we), .waddr(bh_waddr), .wdata(bh_wdata),
    .raddr(rem[BIW-1:0]), .rdata(bh_rdata)
  );

  chm_ram #(.WIDTH(chm_pkg::KEY_W), .DEPTH(POOL_SIZE)) u_node_key (
    .clk(clk), .we(nk_we), .waddr(nk_waddr), .wdata(key_r),
    .raddr(nd_raddr), .rdata(nk_rdata)
  );

  chm_ram #(.WIDTH(chm_pkg::VAL_W), .DEPTH(POOL_SIZE)) u_node_value (
    .clk(clk), .we(nv_we), .waddr(nv_waddr), .wdata(nv_wdata),
    .raddr(nd_raddr), .rdata(nv_rdata)
  );

  chm_ram #(.WIDTH(NW), .DEPTH(POOL_SIZE)) u_node_next (
    .clk(clk), .we(nn_we), .waddr(nn_waddr), .wdata(nn_wdata),
    .raddr(nn_raddr), .rdata(nn_rdata)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state        <= S_CLEAR;
      bucket_count <= chm_pkg::DEFAULT_BUCKETS;
      clr_idx      <= '0;
      clr_pend     <= 1'b0;
      free_head    <= '0;
      entry_total  <= '0;
    end else begin
      if (cfg_we) begin
        bucket_count <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (32'(clr_idx) == SWEEP - 1) begin
            clr_idx     <= '0;
            free_head   <= '0;
            entry_total <= '0;
            state       <= S_IDLE;
            if (clr_pend) begin
              clr_pend    <= 1'b0;
              done        <= 1'b1;
              hit         <= 1'b0;
              value_out   <= '0;
              full_res    <= 1'b0;
              entry_count <= '0;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            mode_r  <= chm_pkg::mode_t'(mode);
            key_r   <= key;
            value_r <= value;
            rem     <= '0;
            bit_cnt <= 5'd31;
            if (chm_pkg::mode_t'(mode) == chm_pkg::MODE_DELALL) begin
              clr_pend <= 1'b1;
              state    <= S_CLEAR;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // restoring division, one key bit a cycle
          if (trial >= {1'b0, neff}) begin
            rem <= CW'(trial - {1'b0, neff});
          end else begin
            rem <= trial[CW-1:0];
          end
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            state <= S_BRD;
          end
        end
        S_BRD: begin
          state <= S_HEAD;
        end
        S_HEAD: begin
          cur   <= bh_rdata;
          head  <= bh_rdata;
          prev  <= NIL;
          state <= S_CHK;
        end
        S_CHK: begin
          if (!cur_nil) begin
            state <= S_CMP;
          end else if (mode_r == chm_pkg::MODE_SET && free_head != NIL) begin
            state <= S_ALLOC;
          end else begin
            done        <= 1'b1;
            hit         <= 1'b0;
            value_out   <= '0;
            full_res    <= (mode_r == chm_pkg::MODE_SET);
            entry_count <= chm_pkg::COUNT_W'(entry_total);
            state       <= S_IDLE;
          end
        end
        S_CMP: begin
          if (key_match) begin
            vout  <= nv_rdata;
            nnext <= nn_rdata;
            if (mode_r == chm_pkg::MODE_DEL) begin
              state <= S_DEL1;
            end else begin
              done        <= 1'b1;
              hit         <= 1'b1;
              value_out   <= nv_rdata;
              full_res    <= 1'b0;
              entry_count <= chm_pkg::COUNT_W'(entry_total);
              state       <= S_IDLE;
            end
          end else begin
            prev  <= cur;
            cur   <= nn_rdata;
            state <= S_CHK;
          end
        end
        S_DEL1: begin
          state <= S_DEL2;
        end
        S_DEL2: begin
          free_head   <= cur;
          entry_total <= entry_total - 1'b1;
          done        <= 1'b1;
          hit         <= 1'b1;
          value_out   <= vout;
          full_res    <= 1'b0;
          entry_count <= chm_pkg::COUNT_W'(entry_total - 1'b1);
          state       <= S_IDLE;
        end
        S_ALLOC: begin
          free_head   <= nn_rdata;
          entry_total <= entry_total + 1'b1;
          done        <= 1'b1;
          hit         <= 1'b0;
          value_out   <= '0;
          full_res    <= 1'b0;
          entry_count <= chm_pkg::COUNT_W'(entry_total + 1'b1);
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CHM_ASSERT(a_full_no_hit, done |-> !(full_res && hit), "full and hit together")
  `CHM_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `CHM_ASSERT(a_full_pool, (done && full_res) |-> (free_head == NIL), "refused with free node")

endmodule
